### src/dcp_pkg.sv
// Shared widths, stage counts and the queue entry type of the distance
// constraint projection block. No dependencies.
package dcp_pkg;

    localparam int COORD_W   = 32;                 // Q16.16 positions
    localparam int MASS_W    = 17;                 // Q16 inverse mass
    localparam int WSUM_W    = MASS_W + 1;         // summed inverse mass
    localparam int REST_W    = 31;                 // rest length
    localparam int MAG_W     = COORD_W + 1;        // |second - first|
    localparam int SQ_W      = 2 * MAG_W;          // squared length, Q32.32
    localparam int ROOT_W    = MAG_W;              // floor(sqrt), Q16.16
    localparam int DEN_W     = ROOT_W + WSUM_W;    // length times mass sum
    localparam int PROD_W    = MAG_W + ROOT_W;     // |d| * |L - R|
    localparam int HALF_W    = PROD_W / 2;         // partial product split
    localparam int PART_W    = HALF_W + MASS_W;
    localparam int NUM_W     = PROD_W + MASS_W;    // dividend
    localparam int QUO_W     = ROOT_W + 1;         // quotient bits produced
    localparam int CORR_W    = QUO_W + 1;          // signed correction
    localparam int SUM_W     = CORR_W + 1;         // coordinate plus correction

    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUO_W;
    localparam int LANES       = 4;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = Q_AW + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [MAG_W-1:0]          adx;
        logic [MAG_W-1:0]          ady;
        logic                      sdx;
        logic                      sdy;
        logic [MASS_W-1:0]         k1;
        logic [MASS_W-1:0]         k2;
        logic [WSUM_W-1:0]         w;
        logic [REST_W-1:0]         rest;
        logic                      degen;
        logic                      lr_neg;
    } dcp_item_t;

endpackage

### src/dcp_if.sv
// Request and result channel interfaces (valid/ready plus payload).
// Depends on dcp_pkg for field widths.
interface dcp_in_if
    import dcp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic [MASS_W-1:0]         first_inv_mass;
    logic [MASS_W-1:0]         second_inv_mass;
    logic [REST_W-1:0]         rest_length;

    modport source (
        output valid, first_x, first_y, second_x, second_y,
               first_inv_mass, second_inv_mass, rest_length,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, second_x, second_y,
               first_inv_mass, second_inv_mass, rest_length,
        output ready
    );
endinterface

interface dcp_out_if
    import dcp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] new_first_x;
    logic signed [COORD_W-1:0] new_first_y;
    logic signed [COORD_W-1:0] new_second_x;
    logic signed [COORD_W-1:0] new_second_y;
    logic                      degenerate;

    modport source (
        output valid, new_first_x, new_first_y, new_second_x, new_second_y,
               degenerate,
        input  ready
    );
    modport sink (
        input  valid, new_first_x, new_first_y, new_second_x, new_second_y,
               degenerate,
        output ready
    );
endinterface

### src/dcp_front.sv
// Front end: accept a request, form differences, magnitudes and mass sum,
// flag degenerate links. Depends on dcp_pkg and dcp_if.
module dcp_front
    import dcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dcp_in_if.sink    item,
    output dcp_item_t push_item,
    output logic      push_valid,
    input  logic      push_ready
);

    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    dcp_item_t               hold_reg;
    dcp_item_t               classified;
    logic signed [MAG_W-1:0] dx;
    logic signed [MAG_W-1:0] dy;

    always_comb
    begin
        dx = $signed({item.second_x[COORD_W-1], item.second_x})
           - $signed({item.first_x[COORD_W-1], item.first_x});
        dy = $signed({item.second_y[COORD_W-1], item.second_y})
           - $signed({item.first_y[COORD_W-1], item.first_y});
        classified.x1     = item.first_x;
        classified.y1     = item.first_y;
        classified.x2     = item.second_x;
        classified.y2     = item.second_y;
        classified.sdx    = dx[MAG_W-1];
        classified.sdy    = dy[MAG_W-1];
        classified.adx    = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        classified.ady    = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        classified.k1     = item.first_inv_mass;
        classified.k2     = item.second_inv_mass;
        classified.w      = WSUM_W'(item.first_inv_mass) + WSUM_W'(item.second_inv_mass);
        classified.rest   = item.rest_length;
        // coincident particles or two fixed particles: pass positions through
        classified.degen  = ((dx == '0) && (dy == '0)) || (classified.w == '0);
        classified.lr_neg = 1'b0;
    end

    assign item.ready = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (item.ready)
        begin
            hold_valid_next = item.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            hold_reg <= classified;
        end
    end

endmodule

### src/dcp_queue.sv
// Short queue between front and back end.
// Depends on dcp_pkg.
module dcp_queue
    import dcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dcp_item_t push_item,
    input  logic      push_valid,
    output logic      push_ready,
    output dcp_item_t pop_item,
    output logic      pop_valid,
    input  logic      pop
);

    dcp_item_t       entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;
    logic            push;

    assign push_ready = count_reg != Q_CW'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_valid && count_reg == Q_CW'(Q_DEPTH) && push_ready))
        else $error("queue accepted a request while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_AW-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

### src/dcp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on dcp_pkg.
module dcp_isqrt
    import dcp_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   s,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0]   rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        localparam int Bit = ROOT_W - 1 - i;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W:0]     trial;
        logic              fit;

        if (i == 0)
        begin : g_first
            assign rem_in  = s;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
        assign trial = ((SQ_W+1)'(root_in) << (Bit + 1)) | ((SQ_W+1)'(1) << (2 * Bit));
        assign fit   = trial <= {1'b0, rem_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fit ? SQ_W'({1'b0, rem_in} - trial) : rem_in;
                root_reg[i] <= fit ? (root_in | (ROOT_W'(1) << Bit)) : root_in;
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

### src/dcp_div.sv
// Pipelined restoring divider, one quotient bit per stage; the quotient is
// known to fit QUO_W bits. Depends on dcp_pkg.
module dcp_div
    import dcp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem,
    output logic [DEN_W-1:0] den_out
);

    logic [DEN_W-1:0] r_reg [DIV_STAGES];
    logic [QUO_W-1:0] lo_reg [DIV_STAGES];
    logic [QUO_W-1:0] q_reg [DIV_STAGES];
    logic [DEN_W-1:0] d_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [DEN_W-1:0] r_in;
        logic [QUO_W-1:0] lo_in;
        logic [QUO_W-1:0] q_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W:0]   shifted;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign r_in  = DEN_W'(num[NUM_W-1:QUO_W]);
            assign lo_in = num[QUO_W-1:0];
            assign q_in  = '0;
            assign d_in  = den;
        end
        else
        begin : g_next
            assign r_in  = r_reg[i-1];
            assign lo_in = lo_reg[i-1];
            assign q_in  = q_reg[i-1];
            assign d_in  = d_reg[i-1];
        end

        assign shifted = {r_in, lo_in[QUO_W-1]};
        assign ge      = shifted >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]  <= ge ? DEN_W'(shifted - {1'b0, d_in}) : shifted[DEN_W-1:0];
                lo_reg[i] <= {lo_in[QUO_W-2:0], 1'b0};
                q_reg[i]  <= {q_in[QUO_W-2:0], ge};
                d_reg[i]  <= d_in;
            end
        end
    end

    assign quo     = q_reg[DIV_STAGES-1];
    assign rem     = r_reg[DIV_STAGES-1];
    assign den_out = d_reg[DIV_STAGES-1];

endmodule

### src/dcp_back.sv
// Back end: squared length, root, products, four dividers, rounding,
// saturation and the result register. Depends on dcp_pkg, dcp_if,
// dcp_isqrt and dcp_div.
module dcp_back
    import dcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dcp_item_t pop_item,
    input  logic      pop_valid,
    output logic      pop,
    dcp_out_if.source result
);

    localparam int ST_SUM   = 2;
    localparam int ST_ROOT  = ST_SUM + SQRT_STAGES;
    localparam int ST_LR    = ST_ROOT + 1;
    localparam int ST_PROD  = ST_LR + 1;
    localparam int ST_PART  = ST_PROD + 1;
    localparam int ST_NUM   = ST_PART + 1;
    localparam int ST_QUO   = ST_NUM + DIV_STAGES;
    localparam int PIPE_LEN = ST_QUO + 2;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
        lo = ~hi;
        if (v > hi)
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return v[COORD_W-1:0];
    endfunction

    logic                         en;
    dcp_item_t                    pl_reg [PIPE_LEN];
    logic [PIPE_LEN-1:0]          vld_reg;
    logic [SQ_W-1:0]              sqx_reg;
    logic [SQ_W-1:0]              sqy_reg;
    logic [SQ_W-1:0]              sum_reg;
    logic [ROOT_W-1:0]            root;
    logic [ROOT_W-1:0]            lrmag_reg;
    logic [DEN_W-1:0]             den_reg;
    logic [DEN_W-1:0]             den_p_reg;
    logic [DEN_W-1:0]             den_q_reg;
    logic [DEN_W-1:0]             den_n_reg;
    logic [PROD_W-1:0]            px_reg;
    logic [PROD_W-1:0]            py_reg;
    logic [LANES-1:0][PROD_W-1:0] lane_prod;
    logic [LANES-1:0][MASS_W-1:0] lane_k;
    logic [LANES-1:0]             lane_sign;
    logic [LANES-1:0][PART_W-1:0] plo_reg;
    logic [LANES-1:0][PART_W-1:0] phi_reg;
    logic [LANES-1:0][NUM_W-1:0]  num_reg;
    logic [LANES-1:0][QUO_W-1:0]  quo;
    logic [LANES-1:0][DEN_W-1:0]  rem;
    logic [LANES-1:0][DEN_W-1:0]  dden;
    logic [LANES-1:0][CORR_W-1:0] lane_mag;
    logic [LANES-1:0][CORR_W-1:0] corr_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [LANES-1:0][COORD_W-1:0] out_reg;
    logic                         out_degen_reg;
    dcp_item_t                    last;
    dcp_item_t                    lr_item;

    // advance the whole pipe whenever the result register can take a value
    assign en   = !out_valid_reg || result.ready;
    assign pop  = en && pop_valid;
    assign last = pl_reg[PIPE_LEN-1];

    // tag the item with the sign of L - R as it leaves the root stage
    always_comb
    begin
        lr_item        = pl_reg[ST_ROOT];
        lr_item.lr_neg = root < ROOT_W'(pl_reg[ST_ROOT].rest);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg[0] <= pop_item;
            for (int k = 1; k < PIPE_LEN; k++)
            begin
                if (k == ST_LR)
                begin
                    pl_reg[k] <= lr_item;
                end
                else
                begin
                    pl_reg[k] <= pl_reg[k-1];
                end
            end
        end
    end

    dcp_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .s    (sum_reg),
        .root (root)
    );

    always_comb
    begin
        lane_prod[0] = px_reg;
        lane_prod[1] = py_reg;
        lane_prod[2] = px_reg;
        lane_prod[3] = py_reg;
        lane_k[0]    = pl_reg[ST_PROD].k1;
        lane_k[1]    = pl_reg[ST_PROD].k1;
        lane_k[2]    = pl_reg[ST_PROD].k2;
        lane_k[3]    = pl_reg[ST_PROD].k2;
        lane_sign[0] = pl_reg[ST_QUO].sdx ^ pl_reg[ST_QUO].lr_neg;
        lane_sign[1] = pl_reg[ST_QUO].sdy ^ pl_reg[ST_QUO].lr_neg;
        lane_sign[2] = lane_sign[0];
        lane_sign[3] = lane_sign[1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= SQ_W'(pl_reg[0].adx) * SQ_W'(pl_reg[0].adx);
            sqy_reg <= SQ_W'(pl_reg[0].ady) * SQ_W'(pl_reg[0].ady);
            sum_reg <= sqx_reg + sqy_reg;
            // |L - R| and L * W
            lrmag_reg <= (root < ROOT_W'(pl_reg[ST_ROOT].rest))
                       ? ROOT_W'(pl_reg[ST_ROOT].rest) - root
                       : root - ROOT_W'(pl_reg[ST_ROOT].rest);
            den_reg   <= DEN_W'(root) * DEN_W'(pl_reg[ST_ROOT].w);
            px_reg    <= PROD_W'(pl_reg[ST_LR].adx) * PROD_W'(lrmag_reg);
            py_reg    <= PROD_W'(pl_reg[ST_LR].ady) * PROD_W'(lrmag_reg);
            den_p_reg <= den_reg;
            den_q_reg <= den_p_reg;
            den_n_reg <= den_q_reg;
            for (int l = 0; l < LANES; l++)
            begin
                plo_reg[l] <= PART_W'(lane_prod[l][HALF_W-1:0]) * PART_W'(lane_k[l]);
                phi_reg[l] <= PART_W'(lane_prod[l][PROD_W-1:HALF_W]) * PART_W'(lane_k[l]);
                num_reg[l] <= NUM_W'(plo_reg[l]) + (NUM_W'(phi_reg[l]) << HALF_W);
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        dcp_div u_div (
            .clk     (clk),
            .en      (en),
            .num     (num_reg[l]),
            .den     (den_n_reg),
            .quo     (quo[l]),
            .rem     (rem[l]),
            .den_out (dden[l])
        );

        // round half away from zero on the magnitude
        assign lane_mag[l] = CORR_W'(quo[l])
                           + CORR_W'({rem[l], 1'b0} >= {1'b0, dden[l]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                corr_reg[l] <= lane_sign[l] ? CORR_W'(-lane_mag[l]) : lane_mag[l];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (en)
        begin
            out_valid_next = vld_reg[PIPE_LEN-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_degen_reg <= last.degen;
            if (last.degen)
            begin
                out_reg[0] <= last.x1;
                out_reg[1] <= last.y1;
                out_reg[2] <= last.x2;
                out_reg[3] <= last.y2;
            end
            else
            begin
                out_reg[0] <= sat_coord(SUM_W'(last.x1) + SUM_W'($signed(corr_reg[0])));
                out_reg[1] <= sat_coord(SUM_W'(last.y1) + SUM_W'($signed(corr_reg[1])));
                out_reg[2] <= sat_coord(SUM_W'(last.x2) - SUM_W'($signed(corr_reg[2])));
                out_reg[3] <= sat_coord(SUM_W'(last.y2) - SUM_W'($signed(corr_reg[3])));
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.new_first_x  = out_reg[0];
    assign result.new_first_y  = out_reg[1];
    assign result.new_second_x = out_reg[2];
    assign result.new_second_y = out_reg[3];
    assign result.degenerate   = out_degen_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_reg[PIPE_LEN-1]))
        else $error("result appeared without an item at the pipe end");
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_ROOT] && !pl_reg[ST_ROOT].degen) |-> root != '0)
        else $error("zero length on a link classified as regular");

endmodule

### src/distance_constraint_projection.sv
// Top level of the 2D distance constraint projection block.
// Depends on dcp_pkg, dcp_if, dcp_front, dcp_queue and dcp_back.
//
// Projects one distance link per request: the length L = floor(sqrt(dx^2+dy^2))
// in Q16.16 is compared with the rest length R, and each particle moves along
// the link by d*(L-R)*k/(L*W), rounded to nearest with ties away from zero,
// first particle toward the second and the second the other way, with each
// coordinate saturated to 32 bits. Coincident particles or a zero inverse
// mass sum pass positions through with degenerate set. A new request can be
// taken every clock cycle while the queue has room; the result register
// decouples the output, and a four-entry queue between the front end and the
// arithmetic pipe lets the front keep accepting while the result side stalls,
// until it is full. A request passes the front register, a queue slot, the
// pipe entry register, the squares and their sum, 33 square root stages (one
// root bit each), the |L - R| and L * W register, the products, the partial
// products, the dividend, 34 divider stages (one quotient bit each), rounding
// and the result register. Stalls freeze the whole arithmetic pipe.
module distance_constraint_projection
    import dcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dcp_in_if.sink    item,
    dcp_out_if.source result
);

    dcp_item_t front_item;
    logic      front_valid;
    logic      front_ready;
    dcp_item_t head_item;
    logic      head_valid;
    logic      head_pop;

    // accept and classify
    dcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready)
    );

    // hold classified requests while the back end is stalled
    dcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (head_item),
        .pop_valid  (head_valid),
        .pop        (head_pop)
    );

    // root, divide, round, saturate, drive the result
    dcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (head_item),
        .pop_valid (head_valid),
        .pop       (head_pop),
        .result    (result)
    );

endmodule

### bench/tb_dcp_if.sv
// Testbench copy point for the channel interfaces: the RTL's dcp_in_if and
// dcp_out_if (src/dcp_if.sv) are used directly. Depends on dcp_pkg.
package tb_dcp_types;
    import dcp_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] nfx;
        logic signed [COORD_W-1:0] nfy;
        logic signed [COORD_W-1:0] nsx;
        logic signed [COORD_W-1:0] nsy;
        logic                      degen;
    } link_result_t;
endpackage

### bench/tb_top.sv
// Self-checking bench for distance_constraint_projection: drives link requests,
// predicts each projected pair and compares results in order.
// Depends on dcp_pkg, dcp_if, tb_dcp_types and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dcp_pkg::*;
    import tb_dcp_types::*;

    localparam int LATENCY = 78;

    logic clk;
    logic rst_n;

    dcp_in_if  req_ch ();
    dcp_out_if res_ch ();

    distance_constraint_projection u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch.sink),
        .result (res_ch.source)
    );

    link_result_t projected_q[$];
    int           mismatches;
    int           idle_pct_src;
    int           idle_pct_dst;
    bit           hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: 1554 requests with heavy stalls stay far below this.
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Round |num| / den to nearest, ties away from zero, and reapply the sign.
    function automatic logic signed [63:0] round_corr(logic signed [33:0] d,
                                                      logic signed [34:0] lr,
                                                      logic [16:0] k,
                                                      logic [63:0] den);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic         neg;
        neg = (d < 0) != (lr < 0);
        num = 128'(d < 0 ? -d : d) * 128'(lr < 0 ? -lr : lr) * 128'(k);
        q = num / 128'(den);
        r = num % 128'(den);
        if (2 * r >= 128'(den)) q = q + 1;
        return neg ? -$signed(64'(q)) : $signed(64'(q));
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Compute the projected positions of one link.
    function automatic link_result_t project_link(logic signed [31:0] x1,
                                                  logic signed [31:0] y1,
                                                  logic signed [31:0] x2,
                                                  logic signed [31:0] y2,
                                                  logic [16:0] k1,
                                                  logic [16:0] k2,
                                                  logic [30:0] rest);
        link_result_t       res;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic [67:0]        sq;
        logic [67:0]        cand;
        logic [33:0]        len;
        logic [17:0]        w;
        logic signed [34:0] lr;
        logic [63:0]        den;
        dx = 34'(x2) - 34'(x1);
        dy = 34'(y2) - 34'(y1);
        sq = 68'(dx < 0 ? -dx : dx) ** 2 + 68'(dy < 0 ? -dy : dy) ** 2;
        len = '0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = 68'(len | (34'd1 << b));
            if (cand * cand <= sq) len = len | (34'd1 << b);
        end
        w = 18'(k1) + 18'(k2);
        res.degen = (len == 0) || (w == 0);
        if (res.degen)
        begin
            res.nfx = x1; res.nfy = y1; res.nsx = x2; res.nsy = y2;
            return res;
        end
        lr  = 35'(len) - 35'(rest);
        den = 64'(len) * 64'(w);
        res.nfx = clamp32(64'(x1) + round_corr(dx, lr, k1, den));
        res.nfy = clamp32(64'(y1) + round_corr(dy, lr, k1, den));
        res.nsx = clamp32(64'(x2) - round_corr(dx, lr, k2, den));
        res.nsy = clamp32(64'(y2) - round_corr(dy, lr, k2, den));
        return res;
    endfunction

    // Offer one request, hold it until accepted; queue its prediction then.
    // Valid stays high on return so the next call can follow back to back.
    task automatic send_link(logic signed [31:0] x1, logic signed [31:0] y1,
                             logic signed [31:0] x2, logic signed [31:0] y2,
                             logic [16:0] k1, logic [16:0] k2, logic [30:0] rest);
        while ($urandom_range(99) < idle_pct_src)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.first_x         <= x1;
        req_ch.first_y         <= y1;
        req_ch.second_x        <= x2;
        req_ch.second_y        <= y2;
        req_ch.first_inv_mass  <= k1;
        req_ch.second_inv_mass <= k2;
        req_ch.rest_length     <= rest;
        do @(posedge clk); while (!req_ch.ready);
        projected_q.push_back(project_link(x1, y1, x2, y2, k1, k2, rest));
        @(negedge clk);
    endtask

    // Result side: stall at random, drop into a long hold-off when asked.
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off) res_ch.ready <= 1'b0;
            else res_ch.ready <= ($urandom_range(99) >= idle_pct_dst);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        link_result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (projected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                exp_r = projected_q.pop_front();
                if (res_ch.new_first_x !== exp_r.nfx || res_ch.new_first_y !== exp_r.nfy
                    || res_ch.new_second_x !== exp_r.nsx
                    || res_ch.new_second_y !== exp_r.nsy
                    || res_ch.degenerate !== exp_r.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                                 exp_r.nfx, exp_r.nfy, exp_r.nsx, exp_r.nsy, exp_r.degen,
                                 res_ch.new_first_x, res_ch.new_first_y,
                                 res_ch.new_second_x, res_ch.new_second_y,
                                 res_ch.degenerate);
                end
            end
        end
    end

    typedef struct {
        logic signed [31:0] x1, y1, x2, y2;
        logic [16:0]        k1, k2;
        logic [30:0]        rest;
        bit                 has_exp;
        logic signed [31:0] ex1, ey1, ex2, ey2;
        logic               edeg;
    } link_row_t;

    link_row_t directed_rows[$];

    task automatic add_row(logic signed [31:0] x1, logic signed [31:0] y1,
                           logic signed [31:0] x2, logic signed [31:0] y2,
                           logic [16:0] k1, logic [16:0] k2, logic [30:0] rest,
                           bit has_exp, logic edeg);
        link_row_t r;
        r = '{x1, y1, x2, y2, k1, k2, rest, has_exp, x1, y1, x2, y2, edeg};
        directed_rows.push_back(r);
    endtask

    // Random coordinate: mostly near values, sometimes the full range.
    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(8000000)) - 32'sd4000000;
            2: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(65536)
                                         : 32'sh80000000 + $urandom_range(65536);
            default: return $signed($urandom_range(200000)) - 32'sd100000;
        endcase
    endfunction

    function automatic logic [16:0] rnd_mass();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom);
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    initial
    begin
        logic signed [31:0] x1, y1, x2, y2;
        logic [16:0]        k1, k2;
        link_row_t          r;
        mismatches   = 0;
        idle_pct_src = 0;
        idle_pct_dst = 0;
        hold_off     = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.first_x = '0; req_ch.first_y = '0;
        req_ch.second_x = '0; req_ch.second_y = '0;
        req_ch.first_inv_mass = '0; req_ch.second_inv_mass = '0;
        req_ch.rest_length = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: coincident particles and zero mass sum pass through.
        add_row(32'sd1000, -32'sd5, 32'sd1000, -32'sd5, 17'd65536, 17'd65536,
                31'd100, 1, 1'b1);
        add_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                17'd0, 17'd1, 31'h7fffffff, 1, 1'b1);
        add_row(32'sd0, 32'sd0, 32'sd65536, 32'sd0, 17'd0, 17'd0, 31'd0, 1, 1'b1);
        add_row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                17'd0, 17'd0, 31'd5, 1, 1'b1);
        // Already at rest length: corrections are zero.
        add_row(32'sd0, 32'sd0, 32'sd196608, 32'sd0, 17'd65536, 17'd65536,
                31'd196608, 1, 1'b0);
        // Rest to be checked against the predictor.
        add_row(32'sd0, 32'sd0, 32'sd196608, 32'sd262144, 17'd65536, 17'd65536,
                31'd0, 0, 1'b0);
        add_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                17'd65536, 17'd65536, 31'd0, 0, 1'b0);
        add_row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                17'h1ffff, 17'h1ffff, 31'h7fffffff, 0, 1'b0);
        add_row(32'sh7fffffff, 32'sd0, 32'sh80000000, 32'sd0, 17'h1ffff, 17'd0,
                31'd0, 0, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sd1, 32'sd0, 17'd1, 17'd0, 31'h7fffffff, 0, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sd1, 32'sd1, 17'd65536, 17'd1, 31'd3, 0, 1'b0);
        add_row(-32'sd100, 32'sd7, 32'sd300, -32'sd9, 17'd0, 17'd65536, 31'd1, 0, 1'b0);
        add_row(32'sh7fff0000, 32'sh7fff0000, -32'sd65536, -32'sd65536, 17'd65536,
                17'd0, 31'h7fffffff, 0, 1'b0);
        add_row(32'sd3, 32'sd4, 32'sd0, 32'sd0, 17'h1ffff, 17'd1, 31'd2, 0, 1'b0);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_link(r.x1, r.y1, r.x2, r.y2, r.k1, r.k2, r.rest);
            // Typed-in result overrides the prediction for readable rows.
            if (r.has_exp)
            begin
                projected_q[projected_q.size()-1].degen = r.edeg;
                projected_q[projected_q.size()-1].nfx   = r.ex1;
                projected_q[projected_q.size()-1].nfy   = r.ey1;
                projected_q[projected_q.size()-1].nsx   = r.ex2;
                projected_q[projected_q.size()-1].nsy   = r.ey2;
            end
        end
        req_ch.valid <= 1'b0;

        // Sender pause: wait until every expected result has come.
        while (projected_q.size() != 0) @(negedge clk);

        // Long receiver hold-off while requests keep coming; the queue fills.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 100; i++)
                begin
                    send_link(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                              rnd_mass(), rnd_mass(), 31'($urandom));
                end
                req_ch.valid <= 1'b0;
            end
        join

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct_src = (ph == 1) ? 45 : (ph == 3) ? 8 : 0;
            idle_pct_dst = (ph == 2) ? 45 : (ph == 3) ? 8 : 0;
            for (int i = 0; i < 360; i++)
            begin
                x1 = rnd_coord();
                y1 = rnd_coord();
                if ($urandom_range(9) == 0)
                begin
                    x2 = x1; y2 = y1;
                end
                else if ($urandom_range(1))
                begin
                    x2 = x1 + ($signed($urandom_range(400000)) - 32'sd200000);
                    y2 = y1 + ($signed($urandom_range(400000)) - 32'sd200000);
                end
                else
                begin
                    x2 = rnd_coord(); y2 = rnd_coord();
                end
                k1 = rnd_mass();
                k2 = rnd_mass();
                send_link(x1, y1, x2, y2, k1, k2,
                          $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(300000)));
            end
        end
        req_ch.valid <= 1'b0;

        idle_pct_dst = 0;
        while (projected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && projected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
